// ===== src/ttm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttm_pkg
// Shared widths, codes, reset values and stage records for the touchpad to
// mouse tap detector.
// ----------------------------------------------------------------------------
package ttm_pkg;

    localparam int COORD_BITS     = 11;
    localparam int DIFF_BITS      = COORD_BITS + 1;
    localparam int DELTA_BITS     = 11;
    localparam int ID_BITS        = 4;
    localparam int TIME_BITS      = 32;
    localparam int TAP_TIME_BITS  = 16;
    localparam int LIMIT_BITS     = 11;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int SQ_BITS        = 2 * COORD_BITS;
    localparam int SUM_BITS       = SQ_BITS + 1;
    localparam int IN_DATA_BITS   = 64;
    localparam int OUT_DATA_BITS  = 24;

    localparam int OUT_DEPTH     = 16;
    localparam int OUT_PTR_BITS  = 4;
    localparam int OUT_CNT_BITS  = OUT_PTR_BITS + 1;

    localparam logic [COORD_BITS-1:0]    CENTER_X_RESET  = COORD_BITS'(512);
    localparam logic [COORD_BITS-1:0]    CENTER_Y_RESET  = COORD_BITS'(512);
    localparam logic [SQ_BITS-1:0]       RADIUS_SQ_RESET = SQ_BITS'(400 * 400);
    localparam logic [TAP_TIME_BITS-1:0] TAP_TIME_RESET  = TAP_TIME_BITS'(250);
    localparam logic [LIMIT_BITS-1:0]    TAP_MOVE_RESET  = LIMIT_BITS'(20);

    typedef enum logic [0:0] {
        OP_DOWN = 1'b0,
        OP_UP   = 1'b1
    } opcode_t;

    typedef enum logic [0:0] {
        KIND_MOTION = 1'b0,
        KIND_BUTTON = 1'b1
    } event_kind_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CENTER_X       = 3'd0,
        REG_CENTER_Y       = 3'd1,
        REG_ACCEPT_RADIUS  = 3'd2,
        REG_TAP_TIME_MS    = 3'd3,
        REG_TAP_MOVE_LIMIT = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]    center_x;
        logic [COORD_BITS-1:0]    center_y;
        logic [SQ_BITS-1:0]       radius_sq;
        logic [TAP_TIME_BITS-1:0] tap_time;
        logic [LIMIT_BITS-1:0]    tap_move_limit;
    } cfg_t;

    typedef struct packed {
        opcode_t                opcode;
        logic [COORD_BITS-1:0]  touch_x;
        logic [COORD_BITS-1:0]  touch_y;
        logic [ID_BITS-1:0]     contact_id;
        logic [TIME_BITS-1:0]   time_ms;
    } touch_item_t;

    typedef struct packed {
        logic                 valid;
        touch_item_t          item;
        logic [SQ_BITS-1:0]   sq_x;
        logic [SQ_BITS-1:0]   sq_y;
    } geom_t;

    typedef struct packed {
        logic                        valid;
        logic                        motion;
        logic                        tap;
        logic signed [DIFF_BITS-1:0] diff_x;
        logic signed [DIFF_BITS-1:0] diff_y;
    } track_t;

    typedef struct packed {
        event_kind_t                  kind;
        logic signed [DELTA_BITS-1:0] delta_x;
        logic signed [DELTA_BITS-1:0] delta_y;
        logic                         pressed;
        logic                         last;
    } result_t;

endpackage
`default_nettype wire

// ===== src/ttm_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttm_cfg_regs
// Configuration register file. The accept radius is kept as its square.
// ----------------------------------------------------------------------------
module ttm_cfg_regs (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [ttm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [ttm_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output ttm_pkg::cfg_t                              cfg
);
    import ttm_pkg::*;

    logic [COORD_BITS-1:0]    center_x_reg;
    logic [COORD_BITS-1:0]    center_y_reg;
    logic [SQ_BITS-1:0]       radius_sq_reg;
    logic [TAP_TIME_BITS-1:0] tap_time_reg;
    logic [LIMIT_BITS-1:0]    tap_move_reg;
    logic [COORD_BITS-1:0]    radius;
    logic                     wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;
    assign radius    = cfg_data[COORD_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg  <= CENTER_X_RESET;
            center_y_reg  <= CENTER_Y_RESET;
            radius_sq_reg <= RADIUS_SQ_RESET;
            tap_time_reg  <= TAP_TIME_RESET;
            tap_move_reg  <= TAP_MOVE_RESET;
        end else if (wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_CENTER_X:       center_x_reg  <= cfg_data[COORD_BITS-1:0];
                REG_CENTER_Y:       center_y_reg  <= cfg_data[COORD_BITS-1:0];
                REG_ACCEPT_RADIUS:  radius_sq_reg <= SQ_BITS'(radius) * SQ_BITS'(radius);
                REG_TAP_TIME_MS:    tap_time_reg  <= cfg_data[TAP_TIME_BITS-1:0];
                REG_TAP_MOVE_LIMIT: tap_move_reg  <= cfg_data[LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = '{
        center_x:       center_x_reg,
        center_y:       center_y_reg,
        radius_sq:      radius_sq_reg,
        tap_time:       tap_time_reg,
        tap_move_limit: tap_move_reg
    };

endmodule
`default_nettype wire

// ===== src/ttm_geom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttm_geom
// Input register and squared-distance stage: squares of the axis distances
// from the circle center.
// ----------------------------------------------------------------------------
module ttm_geom (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    input  ttm_pkg::touch_item_t      in_item,
    input  ttm_pkg::cfg_t             cfg,
    output logic                      s1_valid,
    output ttm_pkg::geom_t            geom
);
    import ttm_pkg::*;

    logic                  s1_valid_reg;
    touch_item_t           s1_item_reg;
    logic                  s2_valid_reg;
    touch_item_t           s2_item_reg;
    logic [SQ_BITS-1:0]    sq_x_reg;
    logic [SQ_BITS-1:0]    sq_y_reg;
    logic [COORD_BITS-1:0] dist_x;
    logic [COORD_BITS-1:0] dist_y;

    always_comb begin
        dist_x = (s1_item_reg.touch_x >= cfg.center_x) ?
                 s1_item_reg.touch_x - cfg.center_x : cfg.center_x - s1_item_reg.touch_x;
        dist_y = (s1_item_reg.touch_y >= cfg.center_y) ?
                 s1_item_reg.touch_y - cfg.center_y : cfg.center_y - s1_item_reg.touch_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            s1_item_reg <= in_item;
        end
        s2_item_reg <= s1_item_reg;
        sq_x_reg    <= SQ_BITS'(dist_x) * SQ_BITS'(dist_x);
        sq_y_reg    <= SQ_BITS'(dist_y) * SQ_BITS'(dist_y);
    end

    assign s1_valid = s1_valid_reg;
    assign geom = '{
        valid: s2_valid_reg,
        item:  s2_item_reg,
        sq_x:  sq_x_reg,
        sq_y:  sq_y_reg
    };

endmodule
`default_nettype wire

// ===== src/ttm_track.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttm_track
// Touch tracker: circle test, touch state, motion steps and tap decision.
// ----------------------------------------------------------------------------
module ttm_track (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  ttm_pkg::geom_t     geom,
    input  ttm_pkg::cfg_t      cfg,
    output ttm_pkg::track_t    track
);
    import ttm_pkg::*;

    logic                  idle_reg;
    logic [TIME_BITS-1:0]  down_time_reg;
    logic [COORD_BITS-1:0] first_x_reg;
    logic [COORD_BITS-1:0] first_y_reg;
    logic [COORD_BITS-1:0] prev_x_reg;
    logic [COORD_BITS-1:0] prev_y_reg;
    logic [LIMIT_BITS-1:0] moved_x_reg;
    logic [LIMIT_BITS-1:0] moved_y_reg;

    logic                        valid_reg;
    logic                        motion_reg;
    logic                        tap_reg;
    logic signed [DIFF_BITS-1:0] diff_x_reg;
    logic signed [DIFF_BITS-1:0] diff_y_reg;

    logic [SUM_BITS-1:0]         dist_sq;
    logic                        in_circle;
    logic                        down_ok;
    logic                        up_hit;
    logic                        tap;
    logic [TIME_BITS-1:0]        elapsed;
    logic signed [DIFF_BITS-1:0] step_x;
    logic signed [DIFF_BITS-1:0] step_y;
    logic [COORD_BITS-1:0]       moved_x_next;
    logic [COORD_BITS-1:0]       moved_y_next;
    logic [COORD_BITS-1:0]       x;
    logic [COORD_BITS-1:0]       y;

    always_comb begin
        x         = geom.item.touch_x;
        y         = geom.item.touch_y;
        dist_sq   = SUM_BITS'(geom.sq_x) + SUM_BITS'(geom.sq_y);
        in_circle = (geom.item.contact_id == '0) &&
                    (dist_sq <= SUM_BITS'(cfg.radius_sq));
        down_ok   = geom.valid && (geom.item.opcode == OP_DOWN) && in_circle;
        up_hit    = geom.valid && (geom.item.opcode == OP_UP);
        elapsed   = geom.item.time_ms - down_time_reg;
        tap       = (elapsed < TIME_BITS'(cfg.tap_time)) &&
                    (moved_x_reg < cfg.tap_move_limit) &&
                    (moved_y_reg < cfg.tap_move_limit);
        step_x    = $signed({1'b0, x}) - $signed({1'b0, prev_x_reg});
        step_y    = $signed({1'b0, y}) - $signed({1'b0, prev_y_reg});
        moved_x_next = (x >= first_x_reg) ? x - first_x_reg : first_x_reg - x;
        moved_y_next = (y >= first_y_reg) ? y - first_y_reg : first_y_reg - y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_reg      <= 1'b1;
            down_time_reg <= '0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            moved_x_reg   <= '0;
            moved_y_reg   <= '0;
        end else if (down_ok) begin
            if (idle_reg) begin
                down_time_reg <= geom.item.time_ms;
                first_x_reg   <= x;
                first_y_reg   <= y;
                moved_x_reg   <= '0;
                moved_y_reg   <= '0;
                idle_reg      <= 1'b0;
            end else begin
                moved_x_reg   <= LIMIT_BITS'(moved_x_next);
                moved_y_reg   <= LIMIT_BITS'(moved_y_next);
            end
            prev_x_reg <= x;
            prev_y_reg <= y;
        end else if (up_hit) begin
            idle_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            motion_reg <= 1'b0;
            tap_reg    <= 1'b0;
        end else begin
            valid_reg  <= geom.valid;
            motion_reg <= down_ok;
            tap_reg    <= up_hit && tap;
        end
    end

    always_ff @(posedge aclk) begin
        diff_x_reg <= idle_reg ? '0 : step_x;
        diff_y_reg <= idle_reg ? '0 : step_y;
    end

    assign track = '{
        valid:  valid_reg,
        motion: motion_reg,
        tap:    tap_reg,
        diff_x: diff_x_reg,
        diff_y: diff_y_reg
    };

endmodule
`default_nettype wire

// ===== src/ttm_format.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttm_format
// Result formatter: scales motion steps (X by half, Y by a third, toward
// zero) and builds the motion beat or the press and release beats.
// ----------------------------------------------------------------------------
module ttm_format (
    input  ttm_pkg::track_t     track,
    output logic [1:0]          wr_count,
    output ttm_pkg::result_t    res0,
    output ttm_pkg::result_t    res1
);
    import ttm_pkg::*;

    localparam int RECIP_SHIFT = DIFF_BITS + 2;
    localparam int PROD_BITS   = DIFF_BITS + RECIP_SHIFT;
    localparam int REM_BITS    = DIFF_BITS + 2;
    localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'((2 ** RECIP_SHIFT) / 3);

    logic signed [DIFF_BITS-1:0] adj_x;
    logic signed [DIFF_BITS-1:0] half_x;
    logic                        neg_y;
    logic [DIFF_BITS-1:0]        mag_y;
    logic [PROD_BITS-1:0]        prod_y;
    logic [DIFF_BITS-1:0]        q0_y;
    logic [REM_BITS-1:0]         rem_y;
    logic [DIFF_BITS-1:0]        q_y;
    logic [DIFF_BITS-1:0]        third_y;
    logic signed [DELTA_BITS-1:0] delta_x;
    logic signed [DELTA_BITS-1:0] delta_y;

    always_comb begin
        adj_x  = track.diff_x + $signed({{(DIFF_BITS-1){1'b0}}, track.diff_x[DIFF_BITS-1]});
        half_x = adj_x >>> 1;
        delta_x = $signed(half_x[DELTA_BITS-1:0]);

        neg_y  = track.diff_y[DIFF_BITS-1];
        mag_y  = neg_y ? $unsigned(-track.diff_y) : $unsigned(track.diff_y);
        prod_y = PROD_BITS'(mag_y) * PROD_BITS'(RECIP);
        q0_y   = prod_y[PROD_BITS-1:RECIP_SHIFT];
        rem_y  = REM_BITS'(mag_y) - (REM_BITS'({q0_y, 1'b0}) + REM_BITS'(q0_y));
        q_y    = (rem_y >= REM_BITS'(3)) ? q0_y + 1'b1 : q0_y;
        third_y = neg_y ? (~q_y + 1'b1) : q_y;
        delta_y = $signed(third_y[DELTA_BITS-1:0]);
    end

    always_comb begin
        if (track.tap) begin
            wr_count = 2'd2;
            res0 = '{kind: KIND_BUTTON, delta_x: '0, delta_y: '0, pressed: 1'b1, last: 1'b0};
        end else begin
            wr_count = track.motion ? 2'd1 : 2'd0;
            res0 = '{kind: KIND_MOTION, delta_x: delta_x, delta_y: delta_y,
                     pressed: 1'b0, last: 1'b1};
        end
        res1 = '{kind: KIND_BUTTON, delta_x: '0, delta_y: '0, pressed: 1'b0, last: 1'b1};
    end

endmodule
`default_nettype wire

// ===== src/ttm_out_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttm_out_fifo
// Result queue: takes up to two beats a cycle, hands out one.
// ----------------------------------------------------------------------------
module ttm_out_fifo (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [1:0]                        wr_count,
    input  ttm_pkg::result_t                       wr_data0,
    input  ttm_pkg::result_t                       wr_data1,
    input  wire logic                              rd_en,
    output ttm_pkg::result_t                       rd_data,
    output logic [ttm_pkg::OUT_CNT_BITS-1:0]       count
);
    import ttm_pkg::*;

    result_t                 mem [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] wr_ptr_reg;
    logic [OUT_PTR_BITS-1:0] rd_ptr_reg;
    logic [OUT_CNT_BITS-1:0] count_reg;
    logic [OUT_PTR_BITS-1:0] wr_ptr_alt;

    assign wr_ptr_alt = wr_ptr_reg + OUT_PTR_BITS'(1);

    always_ff @(posedge aclk) begin
        if (wr_count != 2'd0) begin
            mem[wr_ptr_reg] <= wr_data0;
        end
        if (wr_count == 2'd2) begin
            mem[wr_ptr_alt] <= wr_data1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + OUT_PTR_BITS'(wr_count);
            rd_ptr_reg <= rd_ptr_reg + OUT_PTR_BITS'(rd_en);
            count_reg  <= count_reg + OUT_CNT_BITS'(wr_count) - OUT_CNT_BITS'(rd_en);
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign count   = count_reg;

endmodule
`default_nettype wire

// ===== src/touchpad_to_mouse_tap_detector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// touchpad_to_mouse_tap_detector
// Absolute touch events in, relative mouse motion and tap clicks out.
// ----------------------------------------------------------------------------
// One touch event is taken per clock while s_tready is high. An event passes
// through an input register, a squared-distance register and the tracker
// register, and its result beats are written into the queue before they show
// on the master side. An accepted down beat gives one motion beat; an up beat
// that qualifies as a tap gives a press beat and a release beat; every other
// beat gives none. Results wait in a 16-entry queue; s_tready drops while the
// queue cannot hold two beats for every event in flight and for one more, so
// a run of taps is paced by the master side at one beat per cycle while
// m_tready is high.
// ----------------------------------------------------------------------------
module touchpad_to_mouse_tap_detector (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration write channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [ttm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [ttm_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // touch events
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // touch_x[10:0], touch_y[21:11], contact_id[25:22], time_ms[57:26]
    input  wire logic [ttm_pkg::IN_DATA_BITS-1:0]      s_tdata,
    // opcode[0]
    input  wire logic                                  s_tuser,
    // mouse reports
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // delta_x[10:0], delta_y[21:11], button_pressed[22]
    output logic [ttm_pkg::OUT_DATA_BITS-1:0]          m_tdata,
    // event_kind[0]
    output logic                                       m_tuser,
    output logic                                       m_tlast
);
    import ttm_pkg::*;

    localparam int CREDIT_BITS = OUT_CNT_BITS + 1;

    cfg_t                     cfg;
    touch_item_t              in_item;
    logic                     in_accept;
    logic                     s1_valid;
    geom_t                    geom;
    track_t                   track;
    logic [1:0]               wr_count;
    result_t                  res0;
    result_t                  res1;
    result_t                  head;
    logic [OUT_CNT_BITS-1:0]  count;
    logic [1:0]               in_flight;
    logic [CREDIT_BITS-1:0]   reserved;
    logic                     pop;

    ttm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign in_item = '{
        opcode:     opcode_t'(s_tuser),
        touch_x:    s_tdata[10:0],
        touch_y:    s_tdata[21:11],
        contact_id: s_tdata[25:22],
        time_ms:    s_tdata[57:26]
    };

    // reserve two queue slots for each event in flight and one more event
    assign in_flight = 2'(s1_valid) + 2'(geom.valid) + 2'(track.valid);
    assign reserved  = CREDIT_BITS'(count) + CREDIT_BITS'({in_flight, 1'b0});
    assign s_tready  = reserved <= CREDIT_BITS'(OUT_DEPTH - 2);
    assign in_accept = s_tvalid && s_tready;

    ttm_geom u_geom (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_accept),
        .in_item  (in_item),
        .cfg      (cfg),
        .s1_valid (s1_valid),
        .geom     (geom)
    );

    ttm_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .geom    (geom),
        .cfg     (cfg),
        .track   (track)
    );

    ttm_format u_format (
        .track    (track),
        .wr_count (wr_count),
        .res0     (res0),
        .res1     (res1)
    );

    assign m_tvalid = count != '0;
    assign pop      = m_tvalid && m_tready;

    ttm_out_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_count (wr_count),
        .wr_data0 (res0),
        .wr_data1 (res1),
        .rd_en    (pop),
        .rd_data  (head),
        .count    (count)
    );

    assign m_tdata = {1'b0, head.pressed, head.delta_y, head.delta_x};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule
`default_nettype wire

// ===== dv/touchpad_to_mouse_tap_detector_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touchpad_to_mouse_tap_detector_tb
// Self-checking bench for the touch-to-mouse tap detector. A directed table
// covers circle edges, rejected contacts, wrapped timestamps, truncating
// divides and the tap thresholds. Random touch gestures and noise beats then
// run under several register settings. Both stream sides see random idle
// bursts. Each report beat is checked against table rows or a bench tracker.
// ----------------------------------------------------------------------------
module touchpad_to_mouse_tap_detector_tb;
    import ttm_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int N_DIRECTED      = 26;

    localparam result_t NO_REPORT   = '0;
    localparam result_t MOTION_ZERO = '{kind: KIND_MOTION, delta_x: '0, delta_y: '0,
                                        pressed: 1'b0, last: 1'b1};
    localparam result_t BTN_PRESS   = '{kind: KIND_BUTTON, delta_x: '0, delta_y: '0,
                                        pressed: 1'b1, last: 1'b0};
    localparam result_t BTN_RELEASE = '{kind: KIND_BUTTON, delta_x: '0, delta_y: '0,
                                        pressed: 1'b0, last: 1'b1};

    typedef struct {
        opcode_t               op;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [ID_BITS-1:0]    id;
        logic [TIME_BITS-1:0]  t;
        int                    n_fixed;   // -1: take the tracker's reports
        result_t               r0;
        result_t               r1;
    } stim_row_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [IN_DATA_BITS-1:0]   s_tdata   = '0;
    logic                      s_tuser   = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b1;
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic                      m_tuser;
    logic                      m_tlast;

    // register shadow
    logic [COORD_BITS-1:0]    cfg_cx, cfg_cy, cfg_radius;
    logic [TAP_TIME_BITS-1:0] cfg_tap;
    logic [LIMIT_BITS-1:0]    cfg_limit;

    // touch tracker state
    bit                    touch_idle;
    logic [TIME_BITS-1:0]  down_time;
    logic [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y, moved_x, moved_y;

    result_t   pending_reports[$];
    stim_row_t dir_rows[N_DIRECTED];
    int        fixed_count = -1;
    result_t   fixed_a = '0, fixed_b = '0;
    int        counted_items = 0;
    int        errors = 0;
    int        cycle_count = 0;
    bit        sender_gaps = 1'b1;
    bit        sink_stalls = 1'b1;

    always #6 aclk = ~aclk;

    touchpad_to_mouse_tap_detector DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 50) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            flag_error($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    function automatic void reset_tracker();
        cfg_cx     = CENTER_X_RESET;
        cfg_cy     = CENTER_Y_RESET;
        cfg_radius = 11'd400;
        cfg_tap    = TAP_TIME_RESET;
        cfg_limit  = TAP_MOVE_RESET;
        touch_idle = 1'b1;
        down_time  = '0;
        first_x    = '0;
        first_y    = '0;
        prev_x     = '0;
        prev_y     = '0;
        moved_x    = '0;
        moved_y    = '0;
    endfunction

    function automatic void apply_reg(input cfg_index_t idx, input logic [15:0] v);
        case (idx)
            REG_CENTER_X:       cfg_cx     = v[COORD_BITS-1:0];
            REG_CENTER_Y:       cfg_cy     = v[COORD_BITS-1:0];
            REG_ACCEPT_RADIUS:  cfg_radius = v[COORD_BITS-1:0];
            REG_TAP_TIME_MS:    cfg_tap    = v;
            REG_TAP_MOVE_LIMIT: cfg_limit  = v[LIMIT_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic int abs_gap(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Advance the touch tracker by one event; returns the number of reports.
    function automatic int follow_touch(input touch_item_t ev, output result_t rep_a,
                                        output result_t rep_b, output bit ignored);
        int             xi, yi, ax, ay, dxv, dyv;
        longint         dist2, rad2;
        logic [31:0]    elapsed;
        rep_a   = NO_REPORT;
        rep_b   = NO_REPORT;
        ignored = 1'b0;
        xi      = int'(ev.touch_x);
        yi      = int'(ev.touch_y);
        if (ev.opcode == OP_DOWN) begin
            ax    = abs_gap(xi, int'(cfg_cx));
            ay    = abs_gap(yi, int'(cfg_cy));
            dist2 = longint'(ax) * ax + longint'(ay) * ay;
            rad2  = longint'(cfg_radius) * longint'(cfg_radius);
            if (ev.contact_id != '0 || dist2 > rad2) begin
                ignored = 1'b1;
                return 0;
            end
            dxv = 0;
            dyv = 0;
            if (touch_idle) begin
                down_time  = ev.time_ms;
                first_x    = ev.touch_x;
                first_y    = ev.touch_y;
                moved_x    = '0;
                moved_y    = '0;
                touch_idle = 1'b0;
            end else begin
                dxv     = (xi - int'(prev_x)) / 2;
                dyv     = (yi - int'(prev_y)) / 3;
                moved_x = COORD_BITS'(abs_gap(xi, int'(first_x)));
                moved_y = COORD_BITS'(abs_gap(yi, int'(first_y)));
            end
            prev_x        = ev.touch_x;
            prev_y        = ev.touch_y;
            rep_a.kind    = KIND_MOTION;
            rep_a.delta_x = dxv[DELTA_BITS-1:0];
            rep_a.delta_y = dyv[DELTA_BITS-1:0];
            rep_a.pressed = 1'b0;
            rep_a.last    = 1'b1;
            return 1;
        end
        elapsed    = ev.time_ms - down_time;
        touch_idle = 1'b1;
        if (elapsed < {16'd0, cfg_tap} && moved_x < cfg_limit && moved_y < cfg_limit) begin
            rep_a = BTN_PRESS;
            rep_b = BTN_RELEASE;
            return 2;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        touch_item_t ev;
        result_t     rep_a, rep_b, got, want;
        int          n;
        bit          ignored;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                apply_reg(cfg_index_t'(cfg_index), cfg_data);
            end
            if (s_tvalid && s_tready) begin
                ev.opcode     = opcode_t'(s_tuser);
                ev.touch_x    = s_tdata[10:0];
                ev.touch_y    = s_tdata[21:11];
                ev.contact_id = s_tdata[25:22];
                ev.time_ms    = s_tdata[57:26];
                n = follow_touch(ev, rep_a, rep_b, ignored);
                if (!ignored) begin
                    counted_items++;
                end
                if (fixed_count >= 0) begin
                    n     = fixed_count;
                    rep_a = fixed_a;
                    rep_b = fixed_b;
                end
                if (n >= 1) pending_reports.push_back(rep_a);
                if (n >= 2) pending_reports.push_back(rep_b);
            end
            if (m_tvalid && m_tready) begin
                got.kind    = event_kind_t'(m_tuser);
                got.delta_x = m_tdata[10:0];
                got.delta_y = m_tdata[21:11];
                got.pressed = m_tdata[22];
                got.last    = m_tlast;
                if (pending_reports.size() == 0) begin
                    flag_error("report beat with nothing expected");
                end else begin
                    want = pending_reports.pop_front();
                    check_field("event_kind", got.kind, want.kind);
                    check_field("delta_x", got.delta_x, want.delta_x);
                    check_field("delta_y", got.delta_y, want.delta_y);
                    check_field("button_pressed", got.pressed, want.pressed);
                    check_field("tlast", got.last, want.last);
                end
            end
        end
    end

    // random stalls on the report side
    always begin
        @(negedge aclk);
        if (aresetn && sink_stalls && $urandom_range(0, 7) == 0) begin
            m_tready = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
            m_tready = 1'b1;
        end
    end

    task automatic send_row(input stim_row_t row);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid    = 1'b1;
        s_tuser     = row.op;
        s_tdata     = {6'd0, row.t, row.id, row.y, row.x};
        fixed_count = row.n_fixed;
        fixed_a     = row.r0;
        fixed_b     = row.r1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_reports();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int v);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = v[CFG_DATA_BITS-1:0];
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_config(input int cx, input int cy, input int rad, input int tap,
                               input int lim);
        drain_reports();
        repeat (10) @(posedge aclk);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_ACCEPT_RADIUS, rad);
        write_reg(REG_TAP_TIME_MS, tap);
        write_reg(REG_TAP_MOVE_LIMIT, lim);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic int spread(input int h);
        return int'($urandom_range(0, 2 * h)) - h;
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
        if (v < 0) return '0;
        if (v > 2047) return 11'd2047;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic stim_row_t noise_row();
        stim_row_t row;
        row.op      = opcode_t'($urandom_range(0, 1));
        row.x       = COORD_BITS'($urandom());
        row.y       = COORD_BITS'($urandom());
        row.id      = ($urandom_range(0, 2) == 0) ? 4'($urandom()) : 4'd0;
        row.t       = $urandom();
        row.n_fixed = -1;
        row.r0      = NO_REPORT;
        row.r1      = NO_REPORT;
        return row;
    endfunction

    // One gesture: a down in the circle, a few moves, then an up.
    task automatic run_touch();
        stim_row_t   row;
        int          sx, sy, h, reach, moves;
        int unsigned budget;
        logic [31:0] t;
        h      = int'(cfg_radius) / 2;
        reach  = (cfg_limit > 1) ? int'(cfg_limit) - 1 : 0;
        if ($urandom_range(0, 5) == 0) reach = h;
        moves  = $urandom_range(0, 5);
        budget = cfg_tap / (moves + 2) + 1;
        t      = $urandom();
        sx     = int'(cfg_cx) + spread(h);
        sy     = int'(cfg_cy) + spread(h);
        row    = '{OP_DOWN, clamp_coord(sx), clamp_coord(sy), 4'd0, t, -1,
                   NO_REPORT, NO_REPORT};
        send_row(row);
        repeat (moves) begin
            t     += $urandom_range(0, budget);
            row.x  = clamp_coord(sx + spread(reach));
            row.y  = clamp_coord(sy + spread(reach));
            row.t  = t;
            send_row(row);
        end
        case ($urandom_range(0, 3))
            0, 1:    t += $urandom_range(0, budget);
            2:       t  = t + cfg_tap + $urandom_range(0, 2) - 1;
            default: t  = $urandom();
        endcase
        row.op = OP_UP;
        row.x  = COORD_BITS'($urandom());
        row.y  = COORD_BITS'($urandom());
        row.id = ID_BITS'($urandom());
        row.t  = t;
        send_row(row);
    endtask

    initial begin
        int goal;
        reset_tracker();
        dir_rows = '{
            '{OP_UP,   11'd0,    11'd0,    4'd0,  32'd0,        2, BTN_PRESS, BTN_RELEASE},
            '{OP_DOWN, 11'd512,  11'd512,  4'd0,  32'd1000,     1, MOTION_ZERO, NO_REPORT},
            '{OP_DOWN, 11'd514,  11'd515,  4'd0,  32'd1010,    -1, NO_REPORT, NO_REPORT},
            '{OP_UP,   11'd2047, 11'd2047, 4'd15, 32'd1100,    -1, NO_REPORT, NO_REPORT},
            '{OP_DOWN, 11'd512,  11'd512,  4'd5,  32'd1200,     0, NO_REPORT, NO_REPORT},
            '{OP_DOWN, 11'd0,    11'd0,    4'd0,  32'd1210,     0, NO_REPORT, NO_REPORT},
            '{OP_DOWN, 11'd2047, 11'd2047, 4'd0,  32'd1220,     0, NO_REPORT, NO_REPORT},
            '{OP_DOWN, 11'd912,  11'd512,  4'd0,  32'd1230,     1, MOTION_ZERO, NO_REPORT},
            '{OP_DOWN, 11'd112,  11'd512,  4'd0,  32'd1240,    -1, NO_REPORT, NO_REPORT},
            '{OP_DOWN, 11'd512,  11'd112,  4'd0,  32'd1250,    -1, NO_REPORT, NO_REPORT},
            '{OP_DOWN, 11'd512,  11'd913,  4'd0,  32'd1260,     0, NO_REPORT, NO_REPORT},
            '{OP_UP,   11'd0,    11'd0,    4'd0,  32'd1270,     0, NO_REPORT, NO_REPORT},
            '{OP_DOWN, 11'd513,  11'd512,  4'd0,  32'hFFFF_FFFF, 1, MOTION_ZERO, NO_REPORT},
            '{OP_UP,   11'd0,    11'd0,    4'd0,  32'h0000_001F, -1, NO_REPORT, NO_REPORT},
            '{OP_DOWN, 11'd512,  11'd512,  4'd0,  32'd100,      1, MOTION_ZERO, NO_REPORT},
            '{OP_DOWN, 11'd511,  11'd509,  4'd0,  32'd110,     -1, NO_REPORT, NO_REPORT},
            '{OP_DOWN, 11'd510,  11'd508,  4'd0,  32'd120,     -1, NO_REPORT, NO_REPORT},
            '{OP_DOWN, 11'd530,  11'd512,  4'd15, 32'd125,      0, NO_REPORT, NO_REPORT},
            '{OP_UP,   11'd0,    11'd0,    4'd0,  32'd349,     -1, NO_REPORT, NO_REPORT},
            '{OP_DOWN, 11'd512,  11'd512,  4'd0,  32'd500,      1, MOTION_ZERO, NO_REPORT},
            '{OP_DOWN, 11'd531,  11'd531,  4'd0,  32'd510,     -1, NO_REPORT, NO_REPORT},
            '{OP_UP,   11'd0,    11'd0,    4'd0,  32'd750,      0, NO_REPORT, NO_REPORT},
            '{OP_UP,   11'd1365, 11'd682,  4'd10, 32'd600,     -1, NO_REPORT, NO_REPORT},
            '{OP_DOWN, 11'd532,  11'd512,  4'd0,  32'd800,      1, MOTION_ZERO, NO_REPORT},
            '{OP_DOWN, 11'd512,  11'd512,  4'd0,  32'd810,     -1, NO_REPORT, NO_REPORT},
            '{OP_UP,   11'd0,    11'd0,    4'd0,  32'd820,      0, NO_REPORT, NO_REPORT}
        };
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) begin
            send_row(dir_rows[i]);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: load_config(512, 512, 400, 250, 20);
                1: load_config(0, 0, 2047, 65535, 2047);
                2: load_config(2047, 2047, 0, 0, 0);
                default: load_config($urandom_range(0, 2047), $urandom_range(0, 2047),
                                     $urandom_range(20, 700),
                                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                 : $urandom_range(1, 2000),
                                     $urandom_range(1, 100));
            endcase
            if (ph == N_PHASES - 1) begin
                sender_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            goal = counted_items + ITEMS_PER_PHASE;
            while (counted_items < goal) begin
                if ($urandom_range(0, 99) < 70) begin
                    run_touch();
                end else begin
                    send_row(noise_row());
                end
                if ($urandom_range(0, 199) == 0) begin
                    drain_reports();
                end
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        goal = 0;
        while (pending_reports.size() != 0 && goal < 2000) begin
            @(posedge aclk);
            goal++;
        end
        repeat (12) @(posedge aclk);
        if (pending_reports.size() != 0) begin
            flag_error($sformatf("%0d reports never arrived", pending_reports.size()));
        end
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
